FILE: rtl/core/hsfe_pkg.sv
`timescale 1ns / 1ps

package hsfe_pkg;

  localparam int BUCKETS_MAX_DEF = 4096;
  localparam int ENTRIES_MAX_DEF = 64;
  localparam int VALUE_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF   = 48;

  localparam int DIM_WIDTH = 13;
  localparam int CFG_IDX_WIDTH = 2;

  localparam logic [CFG_IDX_WIDTH-1:0] REG_HASH_DIM  = 2'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_QUAD_EN   = 2'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_KEEP_LIN  = 2'd2;

  localparam logic [1:0] OP_ENTRY  = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_FETCH  = 2'd2;

  localparam logic [DIM_WIDTH-1:0] HASH_DIM_RESET = 13'd4096;

  localparam logic [31:0] MURMUR_C1 = 32'hcc9e2d51;
  localparam logic [31:0] MURMUR_C2 = 32'h1b873593;
  localparam logic [31:0] MURMUR_C3 = 32'h85ebca6b;
  localparam logic [31:0] MURMUR_C4 = 32'hc2b2ae35;
  localparam logic [31:0] MURMUR_E  = 32'he6546b64;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HASH,
    ST_ECACHE,
    ST_MOD,
    ST_BRD,
    ST_BWR,
    ST_QI_RD,
    ST_QI_LAT,
    ST_QJ_RD,
    ST_QJ_LAT,
    ST_FRD,
    ST_FCHK
  } state_e;

endpackage

FILE: rtl/core/hashed_sparse_feature_expansion_core.sv
`timescale 1ns / 1ps

// Feature hashing engine for one sparse vector at a time.
// Requests arrive on the in channel (in_valid_i / in_stall_o) and carry an op,
// a feature index and a value. An entry request hashes the index with two
// MurmurHash3 passes on one shared 33x33 multiplier, reduces the hash modulo
// the dimension with a one-bit-per-cycle remainder unit and, when linear
// terms are kept (quadratic mode off or keep-linear set), adds the value
// into the bucket memory. A finish request in quadratic mode walks every
// cached pair, each entry with itself included, so n entries give
// n * (n + 1) / 2 terms. A fetch request scans the bucket memory from the
// cursor and returns one result on the out channel (out_valid_o /
// out_stall_i); an empty tail ends with valid_res 0 and last 1.
// Only fetch requests produce a result; in_stall_o is high while any
// request is being worked on.
// After reset the bucket memory is cleared, one entry per cycle, before the
// first request is taken; configuration writes are taken at any time. A
// held result waits in the output register while the receiver stalls,
// and the engine then holds before emitting the next.

module hashed_sparse_feature_expansion_core #(
  parameter int BUCKETS_MAX = hsfe_pkg::BUCKETS_MAX_DEF,
  parameter int ENTRIES_MAX = hsfe_pkg::ENTRIES_MAX_DEF,
  parameter int VALUE_WIDTH = hsfe_pkg::VALUE_WIDTH_DEF,
  parameter int SUM_WIDTH   = hsfe_pkg::SUM_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hsfe_pkg::CFG_IDX_WIDTH-1:0]  cfg_index_i,
  input  logic [hsfe_pkg::DIM_WIDTH-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          op_i,
  input  logic [30:0]                         feature_index_i,
  input  logic signed [VALUE_WIDTH-1:0]       entry_value_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [$clog2(BUCKETS_MAX)-1:0]      bucket_index_o,
  output logic signed [SUM_WIDTH-1:0]         bucket_value_o,
  output logic                                valid_res_o,
  output logic                                last_o,
  output logic                                overflow_o
);

  localparam int AW  = $clog2(BUCKETS_MAX);
  localparam int PW  = $clog2(BUCKETS_MAX + 1);
  localparam int EAW = $clog2(ENTRIES_MAX);
  localparam int CW  = $clog2(ENTRIES_MAX + 1);
  localparam int DW  = hsfe_pkg::DIM_WIDTH;
  localparam int VW  = VALUE_WIDTH;
  localparam int SW  = SUM_WIDTH;

  logic [DW-1:0] hash_dim_q;
  logic          quad_en_q;
  logic          keep_lin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_dim_q <= hsfe_pkg::HASH_DIM_RESET;
      quad_en_q  <= 1'b0;
      keep_lin_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        hsfe_pkg::REG_HASH_DIM: hash_dim_q <= cfg_data_i;
        hsfe_pkg::REG_QUAD_EN:  quad_en_q  <= cfg_data_i[0];
        hsfe_pkg::REG_KEEP_LIN: keep_lin_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic [DW-1:0] dim_eff;
  always_comb begin
    if (hash_dim_q == '0) begin
      dim_eff = DW'(1);
    end else if (32'(hash_dim_q) > BUCKETS_MAX) begin
      dim_eff = DW'(BUCKETS_MAX);
    end else begin
      dim_eff = hash_dim_q;
    end
  end

  hsfe_pkg::state_e state_q, state_d;
  logic [4:0]          step_q, step_d;
  logic [31:0]         key_q, key_d;
  logic [31:0]         seed_q, seed_d;
  logic                sec_q, sec_d;
  logic                fin_q, fin_d;
  logic [31:0]         hash_q, hash_d;
  logic [31:0]         sq_q, sq_d;
  logic [VW-1:0]       val_q, val_d;
  logic [31:0]         num_q, num_d;
  logic [DW-1:0]       rem_q, rem_d;
  logic [AW-1:0]       baddr_q, baddr_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [CW-1:0]       i_q, i_d;
  logic [CW-1:0]       j_q, j_d;
  logic [PW-1:0]       cursor_q, cursor_d;
  logic                dropped_q, dropped_d;
  logic signed [65:0]  mul_q;

  logic                out_valid_q, out_valid_d;
  logic [AW-1:0]       out_idx_q, out_idx_d;
  logic [SW-1:0]       out_val_q, out_val_d;
  logic                out_vr_q, out_vr_d;
  logic                out_last_q, out_last_d;
  logic                out_ovf_q, out_ovf_d;

  logic signed [32:0]  mul_a, mul_b;
  logic                mul_en;

  logic [31:0] hc_mem [ENTRIES_MAX];
  logic [31:0] sq_mem [ENTRIES_MAX];
  logic [VW-1:0] vc_mem [ENTRIES_MAX];
  logic [31:0]   hc_rd, sq_rd;
  logic [VW-1:0] vc_rd;
  logic [EAW-1:0] cache_ra;
  logic           cache_we;

  logic [SW-1:0] bk_mem [BUCKETS_MAX];
  logic [SW-1:0] bk_rd;
  logic [AW-1:0] bk_ra, bk_wa;
  logic [SW-1:0] bk_wd;
  logic          bk_we;

  always_ff @(posedge clk_i) begin
    if (cache_we) begin
      hc_mem[cnt_q[EAW-1:0]] <= hash_q;
      sq_mem[cnt_q[EAW-1:0]] <= sq_q;
      vc_mem[cnt_q[EAW-1:0]] <= val_q;
    end
    hc_rd <= hc_mem[cache_ra];
    sq_rd <= sq_mem[cache_ra];
    vc_rd <= vc_mem[cache_ra];
  end

  always_ff @(posedge clk_i) begin
    if (bk_we) begin
      bk_mem[bk_wa] <= bk_wd;
    end
    bk_rd <= bk_mem[bk_ra];
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= mul_a * mul_b;
    end
  end

  logic [31:0] m_lo, h2, h3t, h3, h4, hres;
  logic [DW:0] rem2;
  logic [DW-1:0] rem_next;
  logic        out_free;
  logic        accept;

  assign m_lo = mul_q[31:0];
  assign h2   = {(seed_q ^ m_lo)} << 13 | (seed_q ^ m_lo) >> 19;
  assign h3t  = (m_lo + hsfe_pkg::MURMUR_E) ^ 32'd4;
  assign h3   = h3t ^ (h3t >> 16);
  assign h4   = m_lo ^ (m_lo >> 13);
  assign hres = m_lo ^ (m_lo >> 16);
  assign rem2 = {rem_q, num_q[31]};
  assign rem_next = (rem2 >= {1'b0, dim_eff}) ? DW'(rem2 - {1'b0, dim_eff}) : rem2[DW-1:0];

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != hsfe_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    key_d       = key_q;
    seed_d      = seed_q;
    sec_d       = sec_q;
    fin_d       = fin_q;
    hash_d      = hash_q;
    sq_d        = sq_q;
    val_d       = val_q;
    num_d       = num_q;
    rem_d       = rem_q;
    baddr_d     = baddr_q;
    cnt_d       = cnt_q;
    i_d         = i_q;
    j_d         = j_q;
    cursor_d    = cursor_q;
    dropped_d   = dropped_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_idx_d   = out_idx_q;
    out_val_d   = out_val_q;
    out_vr_d    = out_vr_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    cache_ra    = i_q[EAW-1:0];
    cache_we    = 1'b0;
    bk_ra       = cursor_q[AW-1:0];
    bk_we       = 1'b0;
    bk_wa       = cursor_q[AW-1:0];
    bk_wd       = '0;

    unique case (state_q)
      hsfe_pkg::ST_CLEAR: begin
        bk_we = 1'b1;
        if (cursor_q == PW'(BUCKETS_MAX - 1)) begin
          cursor_d = '0;
          state_d  = hsfe_pkg::ST_IDLE;
        end else begin
          cursor_d = cursor_q + PW'(1);
        end
      end
      hsfe_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (op_i)
            hsfe_pkg::OP_ENTRY: begin
              if (cnt_q == CW'(ENTRIES_MAX)) begin
                dropped_d = 1'b1;
              end else begin
                key_d   = {1'b0, feature_index_i};
                seed_d  = {1'b0, feature_index_i};
                val_d   = entry_value_i;
                sec_d   = 1'b0;
                step_d  = '0;
                state_d = hsfe_pkg::ST_HASH;
              end
            end
            hsfe_pkg::OP_FINISH: begin
              if (quad_en_q && cnt_q != '0) begin
                i_d     = '0;
                fin_d   = 1'b1;
                state_d = hsfe_pkg::ST_QI_RD;
              end
            end
            hsfe_pkg::OP_FETCH: begin
              state_d = hsfe_pkg::ST_FRD;
            end
            default: ;
          endcase
        end
      end
      hsfe_pkg::ST_HASH: begin
        mul_en = 1'b1;
        step_d = step_q + 5'd1;
        unique case (step_q)
          5'd0: begin
            mul_a = {1'b0, key_q};
            mul_b = {1'b0, hsfe_pkg::MURMUR_C1};
          end
          5'd1: begin
            mul_a = {1'b0, m_lo[16:0], m_lo[31:17]};
            mul_b = {1'b0, hsfe_pkg::MURMUR_C2};
          end
          5'd2: begin
            mul_a = {1'b0, h2};
            mul_b = 33'sd5;
          end
          5'd3: begin
            mul_a = {1'b0, h3};
            mul_b = {1'b0, hsfe_pkg::MURMUR_C3};
          end
          5'd4: begin
            mul_a = {1'b0, h4};
            mul_b = {1'b0, hsfe_pkg::MURMUR_C4};
          end
          default: begin
            mul_en = 1'b0;
            step_d = '0;
            if (!sec_q) begin
              hash_d = hres;
              key_d  = seed_q + seed_q;
              sec_d  = 1'b1;
            end else begin
              sq_d    = hres;
              state_d = hsfe_pkg::ST_ECACHE;
            end
          end
        endcase
      end
      hsfe_pkg::ST_ECACHE: begin
        cache_we = 1'b1;
        cnt_d    = cnt_q + CW'(1);
        if (!quad_en_q || keep_lin_q) begin
          mul_en  = 1'b1;
          mul_a   = {{(33 - VW){val_q[VW-1]}}, val_q};
          mul_b   = 33'sd1;
          num_d   = hash_q;
          rem_d   = '0;
          step_d  = '0;
          fin_d   = 1'b0;
          state_d = hsfe_pkg::ST_MOD;
        end else begin
          state_d = hsfe_pkg::ST_IDLE;
        end
      end
      hsfe_pkg::ST_MOD: begin
        rem_d  = rem_next;
        num_d  = {num_q[30:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == 5'd31) begin
          baddr_d = AW'(rem_next);
          state_d = hsfe_pkg::ST_BRD;
        end
      end
      hsfe_pkg::ST_BRD: begin
        bk_ra   = baddr_q;
        state_d = hsfe_pkg::ST_BWR;
      end
      hsfe_pkg::ST_BWR: begin
        bk_we = 1'b1;
        bk_wa = baddr_q;
        bk_wd = bk_rd + mul_q[SW-1:0];
        if (!fin_q) begin
          state_d = hsfe_pkg::ST_IDLE;
        end else if (j_q < cnt_q) begin
          state_d = hsfe_pkg::ST_QJ_RD;
        end else if (i_q + CW'(1) < cnt_q) begin
          i_d     = i_q + CW'(1);
          state_d = hsfe_pkg::ST_QI_RD;
        end else begin
          state_d = hsfe_pkg::ST_IDLE;
        end
      end
      hsfe_pkg::ST_QI_RD: begin
        cache_ra = i_q[EAW-1:0];
        state_d  = hsfe_pkg::ST_QI_LAT;
      end
      hsfe_pkg::ST_QI_LAT: begin
        hash_d  = hc_rd;
        val_d   = vc_rd;
        mul_en  = 1'b1;
        mul_a   = {{(33 - VW){vc_rd[VW-1]}}, vc_rd};
        mul_b   = {{(33 - VW){vc_rd[VW-1]}}, vc_rd};
        num_d   = sq_rd;
        rem_d   = '0;
        step_d  = '0;
        j_d     = i_q + CW'(1);
        state_d = hsfe_pkg::ST_MOD;
      end
      hsfe_pkg::ST_QJ_RD: begin
        cache_ra = j_q[EAW-1:0];
        state_d  = hsfe_pkg::ST_QJ_LAT;
      end
      hsfe_pkg::ST_QJ_LAT: begin
        mul_en  = 1'b1;
        mul_a   = {{(33 - VW){val_q[VW-1]}}, val_q};
        mul_b   = {{(33 - VW){vc_rd[VW-1]}}, vc_rd};
        num_d   = hash_q ^ hc_rd;
        rem_d   = '0;
        step_d  = '0;
        j_d     = j_q + CW'(1);
        state_d = hsfe_pkg::ST_MOD;
      end
      hsfe_pkg::ST_FRD: begin
        if (cursor_q == PW'(BUCKETS_MAX)) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_idx_d   = '0;
            out_val_d   = '0;
            out_vr_d    = 1'b0;
            out_last_d  = 1'b1;
            out_ovf_d   = dropped_q;
            cnt_d       = '0;
            cursor_d    = '0;
            dropped_d   = 1'b0;
            state_d     = hsfe_pkg::ST_IDLE;
          end
        end else begin
          state_d = hsfe_pkg::ST_FCHK;
        end
      end
      hsfe_pkg::ST_FCHK: begin
        if (bk_rd != '0) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            out_idx_d   = cursor_q[AW-1:0];
            out_val_d   = bk_rd;
            out_vr_d    = 1'b1;
            out_last_d  = 1'b0;
            out_ovf_d   = dropped_q;
            bk_we       = 1'b1;
            cursor_d    = cursor_q + PW'(1);
            state_d     = hsfe_pkg::ST_IDLE;
          end
        end else begin
          cursor_d = cursor_q + PW'(1);
          state_d  = hsfe_pkg::ST_FRD;
        end
      end
      default: state_d = hsfe_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hsfe_pkg::ST_CLEAR;
      step_q      <= '0;
      sec_q       <= 1'b0;
      fin_q       <= 1'b0;
      cnt_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      cursor_q    <= '0;
      dropped_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      sec_q       <= sec_d;
      fin_q       <= fin_d;
      cnt_q       <= cnt_d;
      i_q         <= i_d;
      j_q         <= j_d;
      cursor_q    <= cursor_d;
      dropped_q   <= dropped_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    seed_q     <= seed_d;
    hash_q     <= hash_d;
    sq_q       <= sq_d;
    val_q      <= val_d;
    num_q      <= num_d;
    rem_q      <= rem_d;
    baddr_q    <= baddr_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_vr_q   <= out_vr_d;
    out_last_q <= out_last_d;
    out_ovf_q  <= out_ovf_d;
  end

  assign out_valid_o    = out_valid_q;
  assign bucket_index_o = out_idx_q;
  assign bucket_value_o = out_val_q;
  assign valid_res_o    = out_vr_q;
  assign last_o         = out_last_q;
  assign overflow_o     = out_ovf_q;

  a_bucket_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hsfe_pkg::ST_BRD) |-> (32'(baddr_q) < 32'(dim_eff)))
    else $error("bucket address not below the active dimension");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) <= ENTRIES_MAX))
    else $error("entry count above cache capacity");

  a_result_from_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |->
      ($past(state_q) == hsfe_pkg::ST_FRD || $past(state_q) == hsfe_pkg::ST_FCHK))
    else $error("result raised outside a fetch");

  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hsfe_pkg::ST_QJ_RD) |-> (j_q > i_q && j_q < cnt_q))
    else $error("pair index out of order");

endmodule
